FILE: hdl/oledr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED text renderer package
// Shared widths, job record, emitter beat codes and the 5x8 font table.
// ----------------------------------------------------------------------------
package oledr_pkg;

  localparam int DEFAULT_DISPLAY_WIDTH = 128;
  localparam int GLYPH_COUNT   = 36;
  localparam int GLYPH_COLS    = 5;
  localparam int FONT_ENTRIES  = GLYPH_COUNT * GLYPH_COLS;
  localparam int FONT_AW       = 8;
  localparam int GLYPH_W       = 6;
  localparam int COL_W         = 8;
  localparam int PAGE_W        = 3;
  localparam int BEAT_W        = 4;

  localparam logic [COL_W-1:0]  GLYPH_ADVANCE = 8'd6;
  localparam logic [PAGE_W-1:0] LAST_PAGE     = 3'd7;
  localparam logic [7:0]        CMD_PAGE      = 8'hB0;
  localparam logic [7:0]        CMD_COL_LOW   = 8'h00;
  localparam logic [7:0]        CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0]        BLANK_COLUMN  = 8'h00;

  // Emitter beat codes: three commands, five glyph columns, one spacer.
  localparam logic [BEAT_W-1:0] BEAT_PAGE   = 4'd0;
  localparam logic [BEAT_W-1:0] BEAT_COL_LO = 4'd1;
  localparam logic [BEAT_W-1:0] BEAT_COL_HI = 4'd2;
  localparam logic [BEAT_W-1:0] BEAT_GLYPH0 = 4'd3;
  localparam logic [BEAT_W-1:0] BEAT_GLYPH4 = 4'd7;
  localparam logic [BEAT_W-1:0] BEAT_SPACER = 4'd8;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [COL_W-1:0]   col;
    logic [GLYPH_W-1:0] glyph;
  } job_t;

  localparam logic [7:0] FONT_ROM [0:FONT_ENTRIES-1] = '{
    8'h7E, 8'h81, 8'hA5, 8'h81, 8'h7E,
    8'h00, 8'h82, 8'hFF, 8'h80, 8'h00,
    8'hC2, 8'hA1, 8'h91, 8'h89, 8'h86,
    8'h42, 8'h81, 8'h89, 8'h89, 8'h76,
    8'h30, 8'h28, 8'h24, 8'hFF, 8'h20,
    8'h4F, 8'h89, 8'h89, 8'h89, 8'h71,
    8'h7E, 8'h89, 8'h89, 8'h89, 8'h72,
    8'h01, 8'hE1, 8'h19, 8'h05, 8'h03,
    8'h76, 8'h89, 8'h89, 8'h89, 8'h76,
    8'h46, 8'h89, 8'h89, 8'h89, 8'h7E,
    8'h20, 8'h54, 8'h54, 8'h54, 8'h78,
    8'h7F, 8'h48, 8'h44, 8'h44, 8'h38,
    8'h38, 8'h44, 8'h44, 8'h44, 8'h20,
    8'h38, 8'h44, 8'h44, 8'h48, 8'h7F,
    8'h38, 8'h54, 8'h54, 8'h54, 8'h18,
    8'h08, 8'h7E, 8'h09, 8'h01, 8'h02,
    8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E,
    8'h7F, 8'h08, 8'h04, 8'h04, 8'h78,
    8'h00, 8'h44, 8'h7D, 8'h40, 8'h00,
    8'h20, 8'h40, 8'h44, 8'h3D, 8'h00,
    8'h7F, 8'h10, 8'h28, 8'h44, 8'h00,
    8'h00, 8'h41, 8'h7F, 8'h40, 8'h00,
    8'h7C, 8'h04, 8'h18, 8'h04, 8'h78,
    8'h7C, 8'h08, 8'h04, 8'h04, 8'h78,
    8'h38, 8'h44, 8'h44, 8'h44, 8'h38,
    8'h7C, 8'h14, 8'h14, 8'h14, 8'h08,
    8'h08, 8'h14, 8'h14, 8'h18, 8'h7C,
    8'h7C, 8'h08, 8'h04, 8'h04, 8'h08,
    8'h48, 8'h54, 8'h54, 8'h54, 8'h20,
    8'h04, 8'h3F, 8'h44, 8'h40, 8'h20,
    8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C,
    8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C,
    8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C,
    8'h44, 8'h28, 8'h10, 8'h28, 8'h44,
    8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C,
    8'h44, 8'h64, 8'h54, 8'h4C, 8'h44
  };

endpackage

FILE: hdl/oledr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED text renderer input channel
// One character item per handshake, with its optional start position.
// ----------------------------------------------------------------------------
interface oledr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       first_of_string;
  logic [6:0] start_col;
  logic [2:0] start_page;

  modport source (output valid, char_code, first_of_string, start_col, start_page,
                  input ready);
  modport sink   (input valid, char_code, first_of_string, start_col, start_page,
                  output ready);
endinterface

FILE: hdl/oledr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED text renderer output channel
// One controller byte per handshake, tagged command or data.
// ----------------------------------------------------------------------------
interface oledr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_of_char;

  modport source (output valid, out_byte, is_data, last_of_char, input ready);
  modport sink   (input valid, out_byte, is_data, last_of_char, output ready);
endinterface

FILE: hdl/oledr_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED text renderer byte emitter
// Holds one glyph job and sequences its nine bytes through the font ROM.
// ----------------------------------------------------------------------------
module oledr_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  oledr_pkg::job_t job,
  oledr_out_if.source   out_ch
);
  import oledr_pkg::*;

  logic                busy;
  job_t                cur;
  logic [BEAT_W-1:0]   beat;
  logic                adv;
  logic                finishing;
  logic [FONT_AW-1:0]  font_addr;
  logic [7:0]          rom_q;
  logic [7:0]          beat_cmd;
  logic                beat_glyph;

  logic                out_valid;
  logic                out_use_rom;
  logic [7:0]          out_cmd;
  logic                out_is_data;
  logic                out_last;

  assign adv       = !out_valid || out_ch.ready;
  assign finishing = busy && adv && (beat == BEAT_SPACER);
  assign job_ready = !busy || finishing;

  assign beat_glyph = (beat >= BEAT_GLYPH0) && (beat <= BEAT_GLYPH4);
  assign font_addr  = {2'b00, cur.glyph} + {cur.glyph, 2'b00}
                    + FONT_AW'(beat - BEAT_GLYPH0);

  always_comb begin
    unique case (beat)
      BEAT_PAGE:   beat_cmd = CMD_PAGE | {5'd0, cur.page};
      BEAT_COL_LO: beat_cmd = CMD_COL_LOW | {4'd0, cur.col[3:0]};
      BEAT_COL_HI: beat_cmd = CMD_COL_HIGH | {4'd0, cur.col[7:4]};
      default:     beat_cmd = BLANK_COLUMN;
    endcase
  end

  // Font ROM read, registered; hold while the output stalls.
  always_ff @(posedge clk) begin
    if (busy && adv && beat_glyph) begin
      rom_q <= (font_addr < FONT_AW'(FONT_ENTRIES)) ? FONT_ROM[font_addr] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      beat      <= BEAT_PAGE;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        busy <= 1'b1;
        beat <= BEAT_PAGE;
      end else if (finishing) begin
        busy <= 1'b0;
      end else if (busy && adv) begin
        beat <= beat + 1'b1;
      end
      if (adv) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur <= job;
    end
    if (busy && adv) begin
      out_use_rom <= beat_glyph;
      out_cmd     <= beat_cmd;
      out_is_data <= (beat >= BEAT_GLYPH0);
      out_last    <= (beat == BEAT_SPACER);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_byte     = out_use_rom ? rom_q : out_cmd;
  assign out_ch.is_data      = out_is_data;
  assign out_ch.last_of_char = out_last;

endmodule

FILE: hdl/oled_text_page_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED text page renderer
// Turns a character stream into page/column commands and 5x8 glyph columns.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one character item per valid/ready handshake. An item with
//   first_of_string set loads the cursor from start_col/start_page and
//   clears the halted flag. The cursor wraps to column 0 of the next page
//   when the glyph would run past DISPLAY_WIDTH; a wrap past page 7 halts
//   the rest of the string until the next first_of_string.
//   out_ch delivers, per digit or lowercase letter, nine bytes: page, column
//   low nibble and column high nibble commands (is_data low), five font
//   columns and one blank spacer column (is_data high, last_of_char on the
//   spacer). Other characters, and halted ones, produce no bytes.
//   The first byte of a drawn character is registered: the accepted item
//   loads the emitter's job and beat state, then the output register.
//   Bytes go out one per cycle while the receiver holds ready high; the next
//   item is taken in the cycle the spacer byte is issued, keeping bytes back
//   to back. Undrawn items are taken one per cycle while the emitter is free.
//   Reset clears the cursor, the halted flag and all valid state.
//   When the receiver stalls, the output register and the font ROM read
//   hold; the emitter stops and in_ch ready drops once a job is waiting.
// ----------------------------------------------------------------------------
module oled_text_page_renderer_top #(
  parameter int DISPLAY_WIDTH = oledr_pkg::DEFAULT_DISPLAY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  oledr_in_if.sink    in_ch,
  oledr_out_if.source out_ch
);
  import oledr_pkg::*;

  localparam logic [COL_W:0] WIDTH_LIMIT = (COL_W+1)'(DISPLAY_WIDTH);

  // Cursor state
  logic [COL_W-1:0]  cursor_col;
  logic [PAGE_W-1:0] cursor_page;
  logic              halted;

  logic              accept;
  logic              job_ready;
  logic              job_valid;
  job_t              job;

  logic [COL_W-1:0]  col_eff;
  logic [PAGE_W-1:0] page_eff;
  logic              halt_eff;
  logic              wrap;
  logic              stop;
  logic [COL_W-1:0]  col_draw;
  logic [PAGE_W-1:0] page_draw;
  logic              drawable;
  logic [GLYPH_W-1:0] glyph;

  assign in_ch.ready = job_ready;
  assign accept      = in_ch.valid && job_ready;

  // Take the start position on the first item of a string.
  assign col_eff  = in_ch.first_of_string ? {1'b0, in_ch.start_col} : cursor_col;
  assign page_eff = in_ch.first_of_string ? in_ch.start_page : cursor_page;
  assign halt_eff = !in_ch.first_of_string && halted;

  assign wrap      = ({1'b0, col_eff} + {1'b0, GLYPH_ADVANCE}) > WIDTH_LIMIT;
  assign stop      = wrap && (page_eff == LAST_PAGE);
  assign col_draw  = wrap ? '0 : col_eff;
  assign page_draw = wrap ? page_eff + 1'b1 : page_eff;

  // Map digits to glyphs 0..9 and lowercase letters to 10..35.
  always_comb begin
    priority if (in_ch.char_code >= 8'h30 && in_ch.char_code <= 8'h39) begin
      drawable = 1'b1;
      glyph    = GLYPH_W'(in_ch.char_code - 8'h30);
    end else if (in_ch.char_code >= 8'h61 && in_ch.char_code <= 8'h7A) begin
      drawable = 1'b1;
      glyph    = GLYPH_W'(in_ch.char_code - 8'h57);
    end else begin
      drawable = 1'b0;
      glyph    = '0;
    end
  end

  assign job_valid = accept && !halt_eff && !stop && drawable;
  assign job.page  = page_draw;
  assign job.col   = col_draw;
  assign job.glyph = glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_page <= '0;
      halted      <= 1'b0;
    end else if (accept && !halt_eff) begin
      if (stop) begin
        // Halt the string; keep the cursor where it stood.
        cursor_col  <= col_eff;
        cursor_page <= page_eff;
        halted      <= 1'b1;
      end else begin
        cursor_col  <= col_draw + GLYPH_ADVANCE;
        cursor_page <= page_draw;
        halted      <= 1'b0;
      end
    end
  end

  oledr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_ch    (out_ch)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED text page renderer testbench
// Streams character items with random bursts and gaps into the renderer,
// predicts the command/glyph byte stream and checks each output byte.
// ----------------------------------------------------------------------------
module tb;
  import oledr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int DISPLAY_W     = DEFAULT_DISPLAY_WIDTH;
  localparam int RANDOM_ITEMS  = 230;
  localparam int LONG_HOLDOFF  = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DIGIT_GLYPHS  = 10;

  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";
  localparam logic [7:0] CH_UPPER_A = "A";

  // Five font columns per glyph, first column in the top byte: digits, then a..z.
  localparam logic [39:0] GLYPH_BITMAPS [GLYPH_COUNT] = '{
    40'h7E81A5817E, 40'h0082FF8000, 40'hC2A1918986, 40'h4281898976,
    40'h302824FF20, 40'h4F89898971, 40'h7E89898972, 40'h01E1190503,
    40'h7689898976, 40'h468989897E, 40'h2054545478, 40'h7F48444438,
    40'h3844444420, 40'h384444487F, 40'h3854545418, 40'h087E090102,
    40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478,
    40'h3844444438, 40'h7C14141408, 40'h081414187C, 40'h7C08040408,
    40'h4854545420, 40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C, 40'h4464544C44
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_of_char;
  } render_beat_t;

  // Tracks the cursor and the halted flag, and holds the bytes still owed.
  class render_scoreboard;
    render_beat_t expected_q[$];
    logic [7:0]   cur_col;
    logic [2:0]   cur_page;
    bit           halted;
    int           failures;

    function new();
      cur_col  = '0;
      cur_page = '0;
      halted   = 1'b0;
      failures = 0;
    endfunction

    function void push_beat(logic [7:0] b, logic d, logic l);
      render_beat_t beat;
      beat.out_byte     = b;
      beat.is_data      = d;
      beat.last_of_char = l;
      expected_q.push_back(beat);
    endfunction

    // Apply one accepted character; returns 0 when a halted string ignored it.
    function bit note_char(logic [7:0] code, logic first, logic [6:0] scol,
                           logic [2:0] spage);
      logic [5:0]  glyph;
      logic [39:0] cols;
      bit          drawable;
      int          i;
      if (first) begin
        cur_col  = {1'b0, scol};
        cur_page = spage;
        halted   = 1'b0;
      end
      if (halted) return 1'b0;
      if (int'(cur_col) + int'(GLYPH_ADVANCE) > DISPLAY_W) begin
        if (cur_page == LAST_PAGE) begin
          halted = 1'b1;
          return 1'b1;
        end
        cur_col  = '0;
        cur_page = cur_page + 3'd1;
      end
      drawable = 1'b1;
      glyph    = '0;
      if (code >= CH_ZERO && code <= CH_NINE) begin
        glyph = 6'(code - CH_ZERO);
      end else if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
        glyph = 6'(code - CH_LOWER_A + 8'(DIGIT_GLYPHS));
      end else begin
        drawable = 1'b0;
      end
      if (drawable) begin
        cols = GLYPH_BITMAPS[glyph];
        push_beat(CMD_PAGE + {5'd0, cur_page}, 1'b0, 1'b0);
        push_beat(CMD_COL_LOW + {4'd0, cur_col[3:0]}, 1'b0, 1'b0);
        push_beat(CMD_COL_HIGH + {4'd0, cur_col[7:4]}, 1'b0, 1'b0);
        for (i = 0; i < GLYPH_COLS; i++) push_beat(cols[39-8*i -: 8], 1'b1, 1'b0);
        push_beat(BLANK_COLUMN, 1'b1, 1'b1);
      end
      cur_col = cur_col + GLYPH_ADVANCE;
      return 1'b1;
    endfunction

    function void check_byte(logic [7:0] b, logic d, logic l);
      render_beat_t want;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected byte: expected none, actual byte %02h data %b last %b",
                 $time, b, d, l);
        return;
      end
      want = expected_q.pop_front();
      if (want.out_byte !== b || want.is_data !== d || want.last_of_char !== l) begin
        failures++;
        $display("%0t: expected byte %02h data %b last %b, actual byte %02h data %b last %b",
                 $time, want.out_byte, want.is_data, want.last_of_char, b, d, l);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  oledr_in_if  in_if ();
  oledr_out_if out_if ();

  render_scoreboard sb = new();

  // Handshake between the stimulus and the result sink for the long holdoff.
  bit holdoff_req = 1'b0;
  int burst_left  = 0;
  int live_items  = 0;

  always #CLK_HALF clk = ~clk;

  oled_text_page_renderer_top #(
    .DISPLAY_WIDTH(DISPLAY_W)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Offer one character item and hold it until the block takes it. Items go
  // out in bursts; between bursts drop valid for a random number of cycles.
  task automatic send_char(input logic [7:0] code, input logic first,
                           input logic [6:0] scol, input logic [2:0] spage);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    in_if.valid           <= 1'b1;
    in_if.char_code       <= code;
    in_if.first_of_string <= first;
    in_if.start_col       <= scol;
    in_if.start_page      <= spage;
    do @(posedge clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
    void'(sb.note_char(code, first, scol, spage));
    live_items++;
    burst_left--;
  endtask

  // Stop offering and wait until every owed byte has come out.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then random strings.
  initial begin : stimulus
    int         len;
    int         k;
    int         pick;
    bit         holdoff_done;
    bit         pause_done;
    logic [7:0] code;
    logic [6:0] scol;
    logic [2:0] spage;

    holdoff_done = 1'b0;
    pause_done   = 1'b0;
    in_if.valid           <= 1'b0;
    in_if.char_code       <= '0;
    in_if.first_of_string <= 1'b0;
    in_if.start_col       <= '0;
    in_if.start_page      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Range ends of both glyph sets from the top-left corner.
    send_char(CH_ZERO, 1'b1, 7'd0, 3'd0);
    send_char(CH_NINE, 1'b0, 7'd0, 3'd0);
    send_char(CH_LOWER_A, 1'b0, 7'd0, 3'd0);
    send_char(CH_LOWER_Z, 1'b0, 7'd0, 3'd0);
    // Unsupported codes just beside each range and at the code extremes.
    send_char(8'h00, 1'b0, 7'd0, 3'd0);
    send_char(CH_ZERO - 8'd1, 1'b0, 7'h7F, 3'd7);
    send_char(CH_NINE + 8'd1, 1'b0, 7'd0, 3'd0);
    send_char(CH_LOWER_A - 8'd1, 1'b0, 7'd0, 3'd0);
    send_char(CH_LOWER_Z + 8'd1, 1'b0, 7'd0, 3'd0);
    send_char(CH_UPPER_A, 1'b0, 7'd0, 3'd0);
    send_char(8'h80, 1'b0, 7'd0, 3'd0);
    send_char(8'hFF, 1'b0, 7'd0, 3'd0);
    // Glyph that exactly fits at the right edge, then a wrap to the next page.
    send_char("m", 1'b1, 7'd122, 3'd3);
    send_char("q", 1'b0, 7'd0, 3'd0);
    // Wrap past the last page halts; the following items are ignored.
    send_char("x", 1'b1, 7'd127, 3'd7);
    send_char("b", 1'b0, 7'd0, 3'd0);
    send_char("c", 1'b0, 7'd0, 3'd0);
    // Start column too close to the right edge moves to the next page.
    send_char("k", 1'b1, 7'd127, 3'd0);
    // Draw on the last page, then run off its end.
    send_char("e", 1'b1, 7'd120, 3'd7);
    send_char("5", 1'b0, 7'd0, 3'd0);
    send_char("7", 1'b1, 7'd123, 3'd6);
    drain_results();

    // Random strings: a start item, then characters with noise in the start
    // fields, ignored unless first_of_string is set on a rare item. Bias starts
    // toward the right edge and the bottom pages so wraps and halts come often.
    while (live_items < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 9);
      scol  = (pick < 4) ? 7'($urandom_range(0, 127)) :
              (pick < 7) ? 7'($urandom_range(100, 127)) : 7'($urandom_range(0, 20));
      spage = ($urandom_range(0, 1) == 1) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(6, 7));
      len   = $urandom_range(1, 40);
      for (k = 0; k < len && live_items < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)       code = CH_ZERO + 8'($urandom_range(0, 9));
        else if (pick < 7)  code = CH_LOWER_A + 8'($urandom_range(0, 25));
        else if (pick < 9)  code = 8'($urandom_range(CH_NINE + 1, CH_LOWER_A - 1));
        else                code = 8'($urandom_range(0, 255));
        if (k == 0) begin
          send_char(code, 1'b1, scol, spage);
        end else begin
          send_char(code, ($urandom_range(0, 49) == 0), 7'($urandom_range(0, 127)),
                    3'($urandom_range(0, 7)));
        end
      end
      // Stall the output for a long stretch while items keep coming.
      if (!holdoff_done && live_items >= 90) begin
        holdoff_done = 1'b1;
        holdoff_req  = 1'b1;
        burst_left   = 60;
      end
      // Pause the input until the output side has caught up.
      if (!pause_done && live_items >= 170) begin
        pause_done = 1'b1;
        drain_results();
      end
    end

    drain_results();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("oled_text_page_renderer_top: match");
    end else begin
      $display("oled_text_page_renderer_top: mismatch");
    end
    $finish;
  end

  // Result sink: check every accepted byte and drive ready on a pattern of
  // its own that changes mode at random intervals.
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    bit rdy;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        sb.check_byte(out_if.out_byte, out_if.is_data, out_if.last_of_char);
      end
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = LONG_HOLDOFF;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 1) == 1);
          2: rdy = (phase % 3 == 0);
          default: rdy = ($urandom_range(0, 4) != 0);
        endcase
      end
      out_if.ready <= rdy;
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst === 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("oled_text_page_renderer_top: mismatch");
    $finish;
  end

endmodule
